@@ rtl/rmt_pkg.sv @@
// Package for the running median tracker: shared types and sequencer codes.
// No dependencies.
package rmt_pkg;
  typedef logic signed [31:0] sample_t;
  typedef logic signed [32:0] med_t;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] S_RD    = 3'd1;
  localparam logic [ST_W-1:0] S_CMP   = 3'd2;
  localparam logic [ST_W-1:0] S_MRD0  = 3'd3;
  localparam logic [ST_W-1:0] S_MRD1  = 3'd4;
  localparam logic [ST_W-1:0] S_MWAIT = 3'd5;
  localparam logic [ST_W-1:0] S_SUM   = 3'd6;
  localparam logic [ST_W-1:0] S_OUT   = 3'd7;
endpackage

@@ rtl/rmt_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module rmt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/running_median_tracker.sv @@
// Top level of the running median tracker: insertion sequencer and median read-out.
// Depends on rmt_pkg and rmt_ram.
//
//  channel | direction | ports
//  in      | input     | in_valid, in_ready, in_sample
//  out     | output    | out_valid, out_ready, out_median_doubled, out_sample_count, out_dropped
//
// Work per item: an insert shifts each larger held sample one slot up, then writes the new
// sample into the freed slot, and the median is read out; a dropped sample goes straight
// to the median read-out. The RAM's registered read and the shared compare pace each
// shift: each shift reads one entry, compares it, writes it one slot up.
// Reset clears the count and the sequencer; the store needs no clearing pass.
// in_ready is low while an item is in work; a stalled result holds in the output register.
module running_median_tracker #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       in_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [32:0]       out_median_doubled,
  output logic [8:0]               out_sample_count,
  output logic                     out_dropped
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [rmt_pkg::ST_W-1:0] state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  rmt_pkg::sample_t         v_r, v_nxt;
  rmt_pkg::sample_t         lo_r, lo_nxt;
  logic                     drop_r, drop_nxt;
  rmt_pkg::med_t            med_r, med_nxt;

  logic                     we;
  logic [AW-1:0]            waddr, raddr;
  logic [31:0]              wdata, rdata;
  logic [CW-1:0]            mid;

  rmt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign mid       = cnt_r >> 1;
  assign in_ready  = (state_r == rmt_pkg::S_IDLE);
  assign out_valid = (state_r == rmt_pkg::S_OUT);
  assign out_median_doubled = med_r;
  assign out_sample_count   = 9'(cnt_r);
  assign out_dropped        = drop_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    v_nxt     = v_r;
    lo_nxt    = lo_r;
    drop_nxt  = drop_r;
    med_nxt   = med_r;
    we        = 1'b0;
    waddr     = pos_r[AW-1:0];
    wdata     = v_r;
    raddr     = AW'(pos_r - CW'(1));
    case (state_r)
      rmt_pkg::S_IDLE: begin
        if (in_valid) begin
          v_nxt    = in_sample;
          pos_nxt  = cnt_r;
          drop_nxt = (cnt_r == CW'(CAPACITY));
          if (cnt_r == CW'(CAPACITY)) state_nxt = rmt_pkg::S_MRD0;
          else if (cnt_r == '0) state_nxt = rmt_pkg::S_CMP;
          else state_nxt = rmt_pkg::S_RD;
        end
      end
      // issue read of entry pos-1
      rmt_pkg::S_RD: state_nxt = rmt_pkg::S_CMP;
      rmt_pkg::S_CMP: begin
        // shift the larger neighbour up, or drop the sample into its slot
        if (pos_r != '0 && $signed(rdata) > v_r) begin
          we      = 1'b1;
          wdata   = rdata;
          pos_nxt = pos_r - CW'(1);
          if (pos_r == CW'(1)) state_nxt = rmt_pkg::S_CMP;
          else state_nxt = rmt_pkg::S_RD;
        end else begin
          we        = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = rmt_pkg::S_MRD0;
        end
      end
      rmt_pkg::S_MRD0: begin
        raddr     = AW'(mid - CW'(1));
        if (cnt_r[0]) raddr = mid[AW-1:0];
        state_nxt = rmt_pkg::S_MRD1;
      end
      rmt_pkg::S_MRD1: begin
        raddr     = mid[AW-1:0];
        lo_nxt    = rdata;
        state_nxt = rmt_pkg::S_MWAIT;
      end
      // hold the upper middle address so its data is still there for the sum
      rmt_pkg::S_MWAIT: begin
        raddr     = mid[AW-1:0];
        state_nxt = rmt_pkg::S_SUM;
      end
      rmt_pkg::S_SUM: begin
        if (cnt_r[0]) med_nxt = {lo_r, 1'b0};
        else med_nxt = 33'(lo_r) + 33'($signed(rdata));
        state_nxt = rmt_pkg::S_OUT;
      end
      rmt_pkg::S_OUT: if (out_ready) state_nxt = rmt_pkg::S_IDLE;
      default: state_nxt = rmt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmt_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    pos_r  <= pos_nxt;
    v_r    <= v_nxt;
    lo_r   <= lo_nxt;
    drop_r <= drop_nxt;
    med_r  <= med_nxt;
  end
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the running median tracker.
// Needs rmt_pkg and running_median_tracker; predicts each result in-line and compares.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP = 256;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [32:0] out_median_doubled;
  logic [8:0] out_sample_count;
  logic out_dropped;

  typedef struct packed {
    logic signed [32:0] med2;
    logic [8:0]         cnt;
    logic               drop;
  } median_res_t;

  rmt_pkg::sample_t pending_samples[$];
  median_res_t      expected_medians[$];
  rmt_pkg::sample_t held_sorted[$];
  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_off = 0;

  running_median_tracker #(.CAPACITY(CAP)) i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample,
    .out_valid, .out_ready, .out_median_doubled, .out_sample_count, .out_dropped
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Insert after any equal values, then form twice the median of the held set.
  function automatic median_res_t track_median(rmt_pkg::sample_t v);
    median_res_t r;
    int unsigned pos;
    int unsigned n;
    r.drop = 1'b0;
    if (held_sorted.size() < CAP) begin
      pos = held_sorted.size();
      while (pos > 0 && held_sorted[pos-1] > v) pos--;
      held_sorted.insert(pos, v);
    end else begin
      r.drop = 1'b1;
    end
    n = held_sorted.size();
    if (n % 2)
      r.med2 = 33'(held_sorted[n/2]) + 33'(held_sorted[n/2]);
    else
      r.med2 = 33'(held_sorted[n/2-1]) + 33'(held_sorted[n/2]);
    r.cnt = 9'(n);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // Driver: bursts of transfers with random gaps; an empty queue just drops valid.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_sample <= pending_samples.pop_front();
          in_valid  <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict on every accepted transfer at the input.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_medians.push_back(track_median(in_sample));
  end

  // Receiver: own stall pattern, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_off > 0) begin
        hold_off  <= hold_off - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (cycle_count % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Monitor: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    median_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_medians.size() == 0) begin
        $display("unexpected result %0d with nothing pending", results_seen);
        error_count++;
      end else begin
        want = expected_medians.pop_front();
        if (out_median_doubled !== want.med2)
          report_mismatch("median_doubled", out_median_doubled, want.med2);
        if (out_sample_count !== want.cnt)
          report_mismatch("sample_count", out_sample_count, want.cnt);
        if (out_dropped !== want.drop)
          report_mismatch("dropped", out_dropped, want.drop);
        if (out_dropped) drops_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || expected_medians.size() > 0)
      @(posedge clk);
  endtask

  function automatic rmt_pkg::sample_t rand_sample();
    case ($urandom_range(0, 5))
      0: return rmt_pkg::sample_t'($urandom_range(0, 15)) - 8;
      1: return 32'sh7FFFFFFF - rmt_pkg::sample_t'($urandom_range(0, 3));
      2: return 32'sh80000000 + rmt_pkg::sample_t'($urandom_range(0, 3));
      default: return rmt_pkg::sample_t'($urandom);
    endcase
  endfunction

  initial begin
    rmt_pkg::sample_t s;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single sample, extremes, equal values, alternating signs.
    pending_samples.push_back(32'sh7FFFFFFF);
    pending_samples.push_back(32'sh7FFFFFFF);
    pending_samples.push_back(32'sh80000000);
    pending_samples.push_back(32'sh80000000);
    pending_samples.push_back(0);
    pending_samples.push_back(-1);
    pending_samples.push_back(1);
    pending_samples.push_back(32'sh55555555);
    pending_samples.push_back(32'shAAAAAAAA);
    pending_samples.push_back(5);
    pending_samples.push_back(5);
    pending_samples.push_back(5);
    wait_drained();

    // Random fill to well past capacity with a long receiver hold-off to back up the input.
    hold_off = 3000;
    for (int i = 0; i < 400; i++) pending_samples.push_back(rand_sample());
    wait_drained();

    // Full store: every further sample is dropped; vary content anyway.
    for (int i = 0; i < 1200; i++) begin
      s = rand_sample();
      pending_samples.push_back(s);
    end
    wait_drained();
    repeat (600) @(posedge clk);

    $display("covered %0d results, %0d of them dropped with the store full", results_seen,
             drops_seen);
    if (error_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
